[hdl/first_fit_pool_allocator_unit_defines.svh]
// Assertion macros for the first-fit pool allocator checker.
// Included by the checker file only; depends on nothing else.
`ifndef FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define FFPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffpa assertion failed");

// Clocked assertion that also holds during reset.
`define FFPA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("ffpa assertion failed");

`endif

[hdl/ffpa_pkg.sv]
// Shared types and codes of the first-fit pool allocator.
// Used by the top level and by its checker; depends on nothing.
package ffpa_pkg;

   localparam logic [2:0] KIND_ALLOC  = 3'd0;
   localparam logic [2:0] KIND_FREE   = 3'd1;
   localparam logic [2:0] KIND_RESIZE = 3'd2;
   localparam logic [2:0] KIND_STATS  = 3'd3;
   localparam logic [2:0] KIND_REINIT = 3'd4;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_MOVED   = 2'd1;
   localparam logic [1:0] STAT_NOSPACE = 2'd2;
   localparam logic [1:0] STAT_IGNORED = 2'd3;

   localparam int unsigned MIN_PAYLOAD = 8;

   localparam int unsigned RSP_STATUS_LO = 0;
   localparam int unsigned RSP_RES_LO    = 2;
   localparam int unsigned RSP_COPY_LO   = 18;
   localparam int unsigned RSP_USED_LO   = 33;
   localparam int unsigned RSP_FREE_LO   = 48;
   localparam int unsigned RSP_LARGE_LO  = 63;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PREP,
      ST_DISP,
      ST_A_RD,
      ST_A_CHK,
      ST_F_RD,
      ST_F_CHK,
      ST_R_NCHK,
      ST_SP_HEAD,
      ST_SP_TAIL,
      ST_WR_FREE,
      ST_M_RD,
      ST_M_CHK,
      ST_M_NX,
      ST_M_NCHK,
      ST_S_RD,
      ST_S_CHK,
      ST_FIN
   } state_type;

endpackage

[hdl/first_fit_pool_allocator_unit.sv]
// First-fit pool allocator: header store, walking sequencer and result register.
// Depends on ffpa_pkg.
//
//  channel  direction  tdata                                       tuser
//  req      in         address, request_bytes                      kind
//  rsp      out        status, result_address, copy_bytes,         none
//                      used_bytes, free_span, largest_free
//
// Every walk visits block headers in pool order through the registered read of the
// single-port header memory.
// A free adds one merge pass over the pool after its walk.
// Reset is synchronous; while it is high slot 0 is written with one free block
// spanning the pool, and the other entries stay undefined until a block is laid there.
// A stalled result is held in the output register while the next item is taken.
module first_fit_pool_allocator_unit
   import ffpa_pkg::*;
#(
   parameter int unsigned POOL_BYTES   = 16384,
   parameter int unsigned ALIGN_BYTES  = 4,
   parameter int unsigned HEADER_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address[15:0], request_bytes[31:16]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status, result_address, copy_bytes, used_bytes,
                                    // free_span, largest_free, zero fill
);

   localparam int unsigned HDR_SPAN =
      ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int unsigned SLOTS  = POOL_BYTES / ALIGN_BYTES + 1;
   localparam int unsigned IW     = $clog2(SLOTS);
   localparam int unsigned SW     = $clog2(POOL_BYTES + 1);
   localparam int unsigned OW     = ($clog2(POOL_BYTES) + 2 > 18) ? $clog2(POOL_BYTES) + 2 : 18;
   localparam int unsigned DIV_SH = OW + 5;
   localparam int unsigned PW     = OW + DIV_SH + 1;
   localparam int unsigned DIV_MUL = ((2 ** DIV_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;

   localparam logic [OW-1:0] HDR_W     = OW'(HDR_SPAN);
   localparam logic [OW-1:0] POOL_W    = OW'(POOL_BYTES);
   localparam logic [OW-1:0] ALIGN_W   = OW'(ALIGN_BYTES);
   localparam logic [OW-1:0] MIN_W     = OW'(MIN_PAYLOAD);
   localparam logic [OW-1:0] SPLIT_MIN = OW'(HDR_SPAN + MIN_PAYLOAD);
   localparam logic [OW-1:0] INIT_SIZE = OW'(POOL_BYTES - HDR_SPAN);

   state_type state_ff, state_in;
   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] cur_size_ff, cur_size_in;
   logic [OW-1:0] old_size_ff, old_size_in;
   logic [OW-1:0] need_ff, need_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] req_ff, req_in;
   logic [2:0] kind_ff, kind_in;
   logic move_ff, move_in;
   logic [1:0] st_status_ff, st_status_in;
   logic [15:0] st_res_ff, st_res_in;
   logic [14:0] st_copy_ff, st_copy_in;
   logic [OW-1:0] used_sum_ff, used_sum_in;
   logic [OW-1:0] free_sum_ff, free_sum_in;
   logic [OW-1:0] largest_ff, largest_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic [SW:0] mem [SLOTS];
   logic [SW:0] rdata_ff;
   logic mem_we;
   logic [SW:0] mem_wdata;

   logic [OW-1:0] dv_x;
   logic [PW-1:0] dv_prod;
   logic [OW-1:0] dv_q;

   logic rd_used;
   logic [OW-1:0] rd_size, nxt_rd, nxt_cur, remain, tgt, res_off, copy_len;
   logic do_split, is_alloc, split_done, accept;

   assign dv_prod = PW'(dv_x) * PW'(DIV_MUL);
   assign dv_q    = dv_prod[OW+DIV_SH-1:DIV_SH];

   assign rd_used  = rdata_ff[SW];
   assign rd_size  = OW'(rdata_ff[SW-1:0]);
   assign nxt_rd   = off_ff + HDR_W + rd_size;
   assign nxt_cur  = off_ff + HDR_W + cur_size_ff;
   assign remain   = cur_size_ff - need_ff;
   assign do_split = remain >= SPLIT_MIN;
   assign tgt      = OW'(addr_ff) - HDR_W;
   assign res_off  = off_ff + HDR_W;
   assign copy_len = (old_size_ff < OW'(req_ff)) ? old_size_ff : OW'(req_ff);
   assign is_alloc = (kind_ff == KIND_ALLOC) || (kind_ff == KIND_RESIZE && addr_ff == 16'd0);
   assign accept   = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[dv_q[IW-1:0]] <= mem_wdata;
      end
      rdata_ff <= mem[dv_q[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff       <= off_in;
      cur_size_ff  <= cur_size_in;
      old_size_ff  <= old_size_in;
      need_ff      <= need_in;
      addr_ff      <= addr_in;
      req_ff       <= req_in;
      kind_ff      <= kind_in;
      move_ff      <= move_in;
      st_status_ff <= st_status_in;
      st_res_ff    <= st_res_in;
      st_copy_ff   <= st_copy_in;
      used_sum_ff  <= used_sum_in;
      free_sum_ff  <= free_sum_in;
      largest_ff   <= largest_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      cur_size_in  = cur_size_ff;
      old_size_in  = old_size_ff;
      need_in      = need_ff;
      addr_in      = addr_ff;
      req_in       = req_ff;
      kind_in      = kind_ff;
      move_in      = move_ff;
      st_status_in = st_status_ff;
      st_res_in    = st_res_ff;
      st_copy_in   = st_copy_ff;
      used_sum_in  = used_sum_ff;
      free_sum_in  = free_sum_ff;
      largest_in   = largest_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      dv_x         = off_ff;
      split_done   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in      = req_tdata[15:0];
               req_in       = req_tdata[31:16];
               kind_in      = req_tuser;
               move_in      = 1'b0;
               st_status_in = STAT_IGNORED;
               st_res_in    = '0;
               st_copy_in   = '0;
               used_sum_in  = '0;
               free_sum_in  = '0;
               largest_in   = '0;
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            dv_x     = OW'(req_ff) + ALIGN_W - OW'(1);
            need_in  = dv_q;
            state_in = ST_DISP;
         end
         ST_DISP: begin
            dv_x    = '0;
            need_in = ((need_ff * ALIGN_W) < MIN_W) ? MIN_W : need_ff * ALIGN_W;
            off_in  = '0;
            if (is_alloc) begin
               state_in = (req_ff == 16'd0) ? ST_FIN : ST_A_RD;
            end else if (kind_ff == KIND_FREE || kind_ff == KIND_RESIZE) begin
               if (OW'(addr_ff) < HDR_W || OW'(addr_ff) >= POOL_W) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_F_RD;
               end
            end else if (kind_ff == KIND_STATS) begin
               st_status_in = STAT_DONE;
               state_in     = ST_S_RD;
            end else if (kind_ff == KIND_REINIT) begin
               mem_we       = 1'b1;
               mem_wdata    = {1'b0, SW'(INIT_SIZE)};
               st_status_in = STAT_DONE;
               state_in     = ST_FIN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_A_RD: begin
            if (off_ff >= POOL_W) begin
               st_status_in = STAT_NOSPACE;
               st_res_in    = '0;
               state_in     = ST_FIN;
            end else begin
               state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if (!rd_used && rd_size >= need_ff) begin
               cur_size_in = rd_size;
               state_in    = ST_SP_HEAD;
            end else begin
               off_in   = nxt_rd;
               state_in = ST_A_RD;
            end
         end
         ST_F_RD: begin
            if (off_ff >= POOL_W || off_ff > tgt) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            dv_x = nxt_rd;
            if (off_ff != tgt) begin
               off_in   = nxt_rd;
               state_in = ST_F_RD;
            end else if (!rd_used) begin
               state_in = ST_FIN;
            end else begin
               old_size_in = rd_size;
               if (kind_ff == KIND_FREE || req_ff == 16'd0) begin
                  st_status_in = STAT_DONE;
                  st_res_in    = '0;
                  state_in     = ST_WR_FREE;
               end else if (rd_size >= need_ff) begin
                  cur_size_in = rd_size;
                  state_in    = ST_SP_HEAD;
               end else if (nxt_rd < POOL_W) begin
                  state_in = ST_R_NCHK;
               end else begin
                  move_in  = 1'b1;
                  off_in   = '0;
                  state_in = ST_A_RD;
               end
            end
         end
         ST_R_NCHK: begin
            if (!rd_used && (old_size_ff + HDR_W + rd_size) >= need_ff) begin
               cur_size_in = old_size_ff + HDR_W + rd_size;
               state_in    = ST_SP_HEAD;
            end else begin
               move_in  = 1'b1;
               off_in   = '0;
               state_in = ST_A_RD;
            end
         end
         ST_SP_HEAD: begin
            mem_we = 1'b1;
            if (do_split) begin
               mem_wdata = {1'b1, SW'(need_ff)};
               state_in  = ST_SP_TAIL;
            end else begin
               mem_wdata  = {1'b1, SW'(cur_size_ff)};
               split_done = 1'b1;
            end
         end
         ST_SP_TAIL: begin
            dv_x       = off_ff + HDR_W + need_ff;
            mem_we     = 1'b1;
            mem_wdata  = {1'b0, SW'(remain - HDR_W)};
            split_done = 1'b1;
         end
         ST_WR_FREE: begin
            dv_x      = tgt;
            mem_we    = 1'b1;
            mem_wdata = {1'b0, SW'(old_size_ff)};
            off_in    = '0;
            state_in  = ST_M_RD;
         end
         ST_M_RD: begin
            state_in = (off_ff >= POOL_W) ? ST_FIN : ST_M_CHK;
         end
         ST_M_CHK: begin
            cur_size_in = rd_size;
            if (rd_used) begin
               off_in   = nxt_rd;
               state_in = ST_M_RD;
            end else begin
               state_in = ST_M_NX;
            end
         end
         ST_M_NX: begin
            dv_x = nxt_cur;
            if (nxt_cur >= POOL_W) begin
               off_in   = nxt_cur;
               state_in = ST_M_RD;
            end else begin
               state_in = ST_M_NCHK;
            end
         end
         ST_M_NCHK: begin
            if (rd_used) begin
               off_in   = nxt_cur;
               state_in = ST_M_RD;
            end else begin
               cur_size_in = cur_size_ff + HDR_W + rd_size;
               mem_we      = 1'b1;
               mem_wdata   = {1'b0, SW'(cur_size_ff + HDR_W + rd_size)};
               state_in    = ST_M_NX;
            end
         end
         ST_S_RD: begin
            state_in = (off_ff >= POOL_W) ? ST_FIN : ST_S_CHK;
         end
         ST_S_CHK: begin
            if (rd_used) begin
               used_sum_in = used_sum_ff + HDR_W + rd_size;
            end else begin
               free_sum_in = free_sum_ff + HDR_W + rd_size;
               if (rd_size > largest_ff) begin
                  largest_in = rd_size;
               end
            end
            off_in   = nxt_rd;
            state_in = ST_S_RD;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {2'b00, largest_ff[14:0], free_sum_ff[14:0], used_sum_ff[14:0],
                               st_copy_ff, st_res_ff, st_status_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (split_done) begin
         if (move_ff) begin
            st_status_in = STAT_MOVED;
            st_res_in    = res_off[15:0];
            st_copy_in   = copy_len[14:0];
            off_in       = tgt;
            state_in     = ST_WR_FREE;
         end else begin
            st_status_in = STAT_DONE;
            st_res_in    = is_alloc ? res_off[15:0] : addr_ff;
            state_in     = ST_FIN;
         end
      end

      if (reset) begin
         dv_x      = '0;
         mem_we    = 1'b1;
         mem_wdata = {1'b0, SW'(INIT_SIZE)};
      end
   end

endmodule

[hdl/ffpa_checker.sv]
// Port-level checker for the first-fit pool allocator, bound to the top level.
// Depends on ffpa_pkg and first_fit_pool_allocator_unit_defines.svh.
`include "first_fit_pool_allocator_unit_defines.svh"

module ffpa_checker
   import ffpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   logic [1:0]  rsp_status;
   logic [15:0] rsp_res;
   logic [14:0] rsp_copy;

   assign rsp_status = rsp_tdata[RSP_STATUS_LO +: 2];
   assign rsp_res    = rsp_tdata[RSP_RES_LO +: 16];
   assign rsp_copy   = rsp_tdata[RSP_COPY_LO +: 15];

   `FFPA_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `FFPA_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `FFPA_ASSERT(a_fail_no_address, clock, reset, rsp_tvalid && (rsp_status == STAT_NOSPACE || rsp_status == STAT_IGNORED) |-> rsp_res == 16'd0)
   `FFPA_ASSERT(a_copy_only_moved, clock, reset, rsp_tvalid && rsp_status != STAT_MOVED |-> rsp_copy == 15'd0)

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (.*);
